// ----- design/srbu_pkg.sv -----
// types, codes and constants shared by the scoped register bank with undo
// no dependencies
`timescale 1ns / 1ps

package srbu_pkg;

    localparam int NUM_BANKS = 3;
    localparam int DATA_W    = 32;

    localparam logic [1:0] KIND_ASSIGN = 2'd0;
    localparam logic [1:0] KIND_FETCH  = 2'd1;
    localparam logic [1:0] KIND_OPEN   = 2'd2;
    localparam logic [1:0] KIND_CLOSE  = 2'd3;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NO_SCOPE   = 2'd1;
    localparam logic [1:0] STS_LOG_FULL   = 2'd2;
    localparam logic [1:0] STS_SCOPE_FULL = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MARK,
        S_POP_CHK,
        S_POP_WR,
        S_DONE
    } t_state;

    // requests from the sequencer to the undo unit
    typedef struct packed {
        logic push;
        logic pop;
        logic open;
        logic close;
    } t_undo_cmd;

    // undo unit flags seen by the sequencer
    typedef struct packed {
        logic log_full;
        logic scope_full;
        logic scope_empty;
        logic more;
    } t_undo_sts;

endpackage

// ----- design/srbu_if.sv -----
// valid/ready channel interfaces for the request and result words
// no dependencies
`timescale 1ns / 1ps

interface srbu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         bank;
    logic [7:0]         slot;
    logic signed [31:0] new_value;
    logic               is_global;

    modport source (output valid, kind, bank, slot, new_value, is_global, input ready);
    modport sink   (input valid, kind, bank, slot, new_value, is_global, output ready);
endinterface

interface srbu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

// ----- design/srbu_undo.sv -----
// undo log, scope mark stack and their fill and depth counters
// depends on srbu_pkg
`timescale 1ns / 1ps

module srbu_undo #(
    parameter int LOG_DEPTH   = 1024,
    parameter int SCOPE_DEPTH = 64,
    parameter int AW          = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srbu_pkg::t_undo_cmd i_cmd,
    input  logic [AW-1:0]      i_push_addr,
    input  logic [31:0]        i_push_val,
    output srbu_pkg::t_undo_sts o_sts,
    output logic [AW-1:0]      o_pop_addr,
    output logic [31:0]        o_pop_val
);
    import srbu_pkg::*;

    localparam int LW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FW = $clog2(LOG_DEPTH + 1);
    localparam int SW = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
    localparam int DW = $clog2(SCOPE_DEPTH + 1);
    localparam int EW = AW + DATA_W;

    logic [EW-1:0] r_log [LOG_DEPTH];
    logic [FW-1:0] r_marks [SCOPE_DEPTH];

    logic [FW-1:0] r_fill, n_fill;
    logic [DW-1:0] r_depth, n_depth;
    logic [FW-1:0] r_mark;
    logic [EW-1:0] r_pop;

    logic [FW-1:0] w_fill_dec;
    logic [DW-1:0] w_depth_dec;

    assign w_fill_dec  = r_fill - FW'(1);
    assign w_depth_dec = r_depth - DW'(1);

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.push) begin
            n_fill = r_fill + FW'(1);
        end else if (i_cmd.pop) begin
            n_fill = w_fill_dec;
        end
        n_depth = r_depth;
        if (i_cmd.open) begin
            n_depth = r_depth + DW'(1);
        end else if (i_cmd.close) begin
            n_depth = w_depth_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_depth <= '0;
        end else begin
            r_fill  <= n_fill;
            r_depth <= n_depth;
        end
    end

    // log memory: one write, one registered read at the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_log[r_fill[LW-1:0]] <= {i_push_addr, i_push_val};
        end
        r_pop <= r_log[w_fill_dec[LW-1:0]];
    end

    // mark memory: the mark is fetched as the scope closes
    always_ff @(posedge i_clk) begin
        if (i_cmd.open) begin
            r_marks[r_depth[SW-1:0]] <= r_fill;
        end
        if (i_cmd.close) begin
            r_mark <= r_marks[w_depth_dec[SW-1:0]];
        end
    end

    assign o_sts.log_full    = (r_fill == FW'(LOG_DEPTH));
    assign o_sts.scope_full  = (r_depth == DW'(SCOPE_DEPTH));
    assign o_sts.scope_empty = (r_depth == '0);
    assign o_sts.more        = (r_fill > r_mark);
    assign o_pop_addr        = r_pop[EW-1:DATA_W];
    assign o_pop_val         = r_pop[DATA_W-1:0];

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LOG_DEPTH))
        else $error("undo log fill beyond depth");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(SCOPE_DEPTH))
        else $error("scope depth beyond stack size");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_fill != FW'(LOG_DEPTH)))
        else $error("push into full undo log");
    a_pop_above_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_fill > r_mark))
        else $error("pop below scope mark");
`endif

endmodule

// ----- design/scoped_register_bank_with_undo_core.sv -----
// top level of the scoped register bank with undo; depends on srbu_pkg, srbu_if and srbu_undo
// sequence from accept: decode then done with no store read (open, close with nothing open,
// unlogged or dropped assign, bank or slot out of range); decode, read, done for a fetch or a
// logged assign; a close runs decode, mark, pop check and pop write per restored log entry, a last pop check, done
// flow: one word at a time; ready again once done loads the result, and a word is held in done
// while the previous result waits for the sink
// reset: synchronous; a clearing pass zeroes every cell of the store, not ready meanwhile
`timescale 1ns / 1ps

module scoped_register_bank_with_undo_core #(
    parameter int SLOTS       = 256,
    parameter int LOG_DEPTH   = 1024,
    parameter int SCOPE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srbu_in_if.sink    i_in,
    srbu_out_if.source o_out
);
    import srbu_pkg::*;

    localparam int CELLS = NUM_BANKS * SLOTS;
    localparam int AW    = $clog2(CELLS);

    logic [DATA_W-1:0] r_store [CELLS];

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr;
    logic [1:0]        r_kind;
    logic [AW-1:0]     r_addr;
    logic              r_cell_ok;
    logic [DATA_W-1:0] r_value;
    logic              r_global;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_res_val, n_res_val;
    logic [1:0]        r_res_st, n_res_st;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_val;
    logic [1:0]        r_out_st;

    logic              w_accept;
    logic              w_out_free;
    logic              w_logged;
    logic              w_load;
    logic [AW-1:0]     w_in_addr;
    logic              w_in_ok;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    t_undo_cmd         w_cmd;
    t_undo_sts         w_sts;
    logic [AW-1:0]     w_pop_addr;
    logic [DATA_W-1:0] w_pop_val;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_logged   = !r_global && !w_sts.scope_empty;

    assign w_in_addr = AW'(i_in.bank) * AW'(SLOTS) + AW'(i_in.slot);
    assign w_in_ok   = (i_in.bank < 2'(NUM_BANKS)) && ({1'b0, i_in.slot} < 9'(SLOTS));

    srbu_undo #(
        .LOG_DEPTH   (LOG_DEPTH),
        .SCOPE_DEPTH (SCOPE_DEPTH),
        .AW          (AW)
    ) u_undo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_push_addr (r_addr),
        .i_push_val  (r_rdata),
        .o_sts       (w_sts),
        .o_pop_addr  (w_pop_addr),
        .o_pop_val   (w_pop_val)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_kind)
                    KIND_ASSIGN: begin
                        if (r_cell_ok && w_logged && !w_sts.log_full) begin
                            n_state = S_READ;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    KIND_FETCH: begin
                        n_state = r_cell_ok ? S_READ : S_DONE;
                    end
                    KIND_OPEN: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = w_sts.scope_empty ? S_DONE : S_MARK;
                    end
                endcase
            end
            S_READ:    n_state = S_DONE;
            S_MARK:    n_state = S_POP_CHK;
            S_POP_CHK: n_state = w_sts.more ? S_POP_WR : S_DONE;
            S_POP_WR:  n_state = S_POP_CHK;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_addr;
        w_wdata   = r_value;
        w_cmd     = '0;
        w_load    = 1'b0;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_DECODE: begin
                n_res_val = '0;
                n_res_st  = STS_OK;
                case (r_kind)
                    KIND_ASSIGN: begin
                        if (r_cell_ok) begin
                            if (w_logged) begin
                                if (w_sts.log_full) begin
                                    n_res_st = STS_LOG_FULL;
                                end
                            end else begin
                                w_we = 1'b1;
                            end
                        end
                    end
                    KIND_FETCH: begin
                        n_res_val = '0;
                    end
                    KIND_OPEN: begin
                        if (w_sts.scope_full) begin
                            n_res_st = STS_SCOPE_FULL;
                        end else begin
                            w_cmd.open = 1'b1;
                        end
                    end
                    default: begin
                        if (w_sts.scope_empty) begin
                            n_res_st = STS_NO_SCOPE;
                        end else begin
                            w_cmd.close = 1'b1;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (r_kind == KIND_FETCH) begin
                    n_res_val = r_rdata;
                end else begin
                    // log the old value, then overwrite
                    w_cmd.push = 1'b1;
                    w_we       = 1'b1;
                end
            end
            S_POP_CHK: begin
                w_cmd.pop = w_sts.more;
            end
            S_POP_WR: begin
                w_we    = 1'b1;
                w_waddr = w_pop_addr;
                w_wdata = w_pop_val;
            end
            S_DONE: begin
                w_load = w_out_free;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_load || (r_out_valid && !o_out.ready);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_in.kind;
            r_addr    <= w_in_addr;
            r_cell_ok <= w_in_ok;
            r_value   <= i_in.new_value;
            r_global  <= i_in.is_global;
        end
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        if (w_load) begin
            r_out_val <= r_res_val;
            r_out_st  <= r_res_st;
        end
    end

    // register store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rdata <= r_store[r_addr];
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_val;
    assign o_out.status     = r_out_st;

`ifndef NO_ASSERTIONS
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done state");
    a_restore_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WR) |-> $past(w_cmd.pop))
        else $error("restore write without a log pop");
`endif

endmodule

// ----- test/tb_scoped_register_bank_with_undo_core.sv -----
// testbench for scoped_register_bank_with_undo_core: directed, overflow and random words
// checked against a scoreboard of the register banks, undo log and scope marks
// depends on srbu_pkg, srbu_if and the core
`timescale 1ns / 1ps

module tb_scoped_register_bank_with_undo_core;
    import srbu_pkg::*;

    localparam int SLOTS       = 256;
    localparam int LOG_DEPTH   = 1024;
    localparam int SCOPE_DEPTH = 64;
    localparam int RANDOM_WORDS = 600;

    localparam logic [1:0] BANK_COUNT = 2'd0;
    localparam logic [1:0] BANK_DIMEN = 2'd1;
    localparam logic [1:0] BANK_GLUE  = 2'd2;
    localparam logic [1:0] BANK_NONE  = 2'd3;

    localparam int READY_ALWAYS   = 0;
    localparam int READY_COIN     = 1;
    localparam int READY_SPARSE   = 2;
    localparam int READY_PERIODIC = 3;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_reply;

    typedef struct packed {
        logic [1:0]         bank;
        logic [7:0]         slot;
        logic signed [31:0] value;
    } t_saved_reg;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srbu_in_if  in_if();
    srbu_out_if out_if();

    scoped_register_bank_with_undo_core #(
        .SLOTS       (SLOTS),
        .LOG_DEPTH   (LOG_DEPTH),
        .SCOPE_DEPTH (SCOPE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scoreboard copy of the block state
    logic signed [31:0] bank_regs [NUM_BANKS][SLOTS];
    t_saved_reg         undo_entries [LOG_DEPTH];
    int unsigned        scope_mark_at [SCOPE_DEPTH];
    int unsigned        undo_fill;
    int unsigned        scope_level;

    t_reply awaited_replies [$];
    int     mismatches = 0;
    int     burst_left = 0;

    function automatic t_reply bank_step(input logic [1:0] kind, input logic [1:0] bank,
                                         input logic [7:0] slot,
                                         input logic signed [31:0] value,
                                         input logic is_glob);
        t_reply     reply;
        logic       reg_ok;
        t_saved_reg rec;
        reg_ok = (bank < NUM_BANKS) && (slot < SLOTS);
        reply.read_value = '0;
        reply.status     = STS_OK;
        case (kind)
            KIND_ASSIGN: begin
                if (reg_ok) begin
                    if (!is_glob && scope_level > 0 && undo_fill == LOG_DEPTH) begin
                        reply.status = STS_LOG_FULL;
                    end else begin
                        if (!is_glob && scope_level > 0) begin
                            undo_entries[undo_fill] = '{bank, slot, bank_regs[bank][slot]};
                            undo_fill++;
                        end
                        bank_regs[bank][slot] = value;
                    end
                end
            end
            KIND_FETCH: begin
                if (reg_ok)
                    reply.read_value = bank_regs[bank][slot];
            end
            KIND_OPEN: begin
                if (scope_level == SCOPE_DEPTH) begin
                    reply.status = STS_SCOPE_FULL;
                end else begin
                    scope_mark_at[scope_level] = undo_fill;
                    scope_level++;
                end
            end
            default: begin
                if (scope_level == 0) begin
                    reply.status = STS_NO_SCOPE;
                end else begin
                    scope_level--;
                    // newest first, so the oldest saved value is what stays
                    while (undo_fill > scope_mark_at[scope_level]) begin
                        undo_fill--;
                        rec = undo_entries[undo_fill];
                        bank_regs[rec.bank][rec.slot] = rec.value;
                    end
                end
            end
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
        mismatches++;
    endtask

    // one word onto the request channel, bursts and gaps decided here
    task automatic send_word(input logic [1:0] kind, input logic [1:0] bank,
                             input logic [7:0] slot, input logic signed [31:0] value,
                             input logic is_glob);
        int idle;
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.bank      <= bank;
        in_if.slot      <= slot;
        in_if.new_value <= value;
        in_if.is_global <= is_glob;
        do @(posedge i_clk); while (!in_if.ready);
        awaited_replies.insert(awaited_replies.size(),
                               bank_step(kind, bank, slot, value, is_glob));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle       = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // result channel: compare each word with the oldest expectation
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected result", '0, out_if.read_value);
            end else begin
                want = awaited_replies.pop_front();
                if (out_if.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, out_if.read_value);
                if (out_if.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(out_if.status));
            end
        end
    end

    // receiver stalls in stretches of changing character
    int stall_mode = READY_ALWAYS;
    int mode_left  = 0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(READY_ALWAYS, READY_PERIODIC);
            mode_left  = $urandom_range(16, 160);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            READY_ALWAYS: out_if.ready <= 1'b1;
            READY_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: out_if.ready <= ($urandom_range(0, 4) == 0);
            default:      out_if.ready <= (mode_left % 3 == 0);
        endcase
    end

    task automatic test_directed();
        // cleared store, extremes, dead bank, close with nothing open
        send_word(KIND_FETCH,  BANK_COUNT, 8'd0,   32'sh12345678, 1'b1);
        send_word(KIND_FETCH,  BANK_GLUE,  8'd255, 32'sd0,        1'b0);
        send_word(KIND_ASSIGN, BANK_COUNT, 8'd0,   32'sh7fffffff, 1'b0);
        send_word(KIND_ASSIGN, BANK_DIMEN, 8'd255, 32'sh80000000, 1'b0);
        send_word(KIND_ASSIGN, BANK_GLUE,  8'd128, -32'sd1,       1'b1);
        send_word(KIND_ASSIGN, BANK_NONE,  8'd5,   32'sd123,      1'b0);
        send_word(KIND_FETCH,  BANK_COUNT, 8'd0,   32'sd0,        1'b0);
        send_word(KIND_FETCH,  BANK_DIMEN, 8'd255, 32'sd0,        1'b0);
        send_word(KIND_FETCH,  BANK_GLUE,  8'd128, 32'sd0,        1'b0);
        send_word(KIND_FETCH,  BANK_NONE,  8'd5,   32'sd0,        1'b0);
        send_word(KIND_CLOSE,  BANK_NONE,  8'd255, -32'sd1,       1'b1);
        // nested scopes with local and global writes
        send_word(KIND_OPEN,   BANK_NONE,  8'd255, -32'sd1,       1'b1);
        send_word(KIND_ASSIGN, BANK_COUNT, 8'd0,   32'sd1,        1'b0);
        send_word(KIND_ASSIGN, BANK_COUNT, 8'd0,   32'sd2,        1'b0);
        send_word(KIND_ASSIGN, BANK_DIMEN, 8'd255, 32'sd5,        1'b1);
        send_word(KIND_FETCH,  BANK_COUNT, 8'd0,   32'sd0,        1'b0);
        send_word(KIND_OPEN,   BANK_COUNT, 8'd0,   32'sd0,        1'b0);
        send_word(KIND_ASSIGN, BANK_GLUE,  8'd128, 32'sh55aa55aa, 1'b0);
        send_word(KIND_ASSIGN, BANK_NONE,  8'd128, 32'sd9,        1'b0);
        send_word(KIND_CLOSE,  BANK_COUNT, 8'd0,   32'sd0,        1'b0);
        send_word(KIND_FETCH,  BANK_GLUE,  8'd128, 32'sd0,        1'b0);
        send_word(KIND_CLOSE,  BANK_GLUE,  8'd7,   32'sd77,       1'b0);
        send_word(KIND_FETCH,  BANK_COUNT, 8'd0,   32'sd0,        1'b0);
        send_word(KIND_FETCH,  BANK_DIMEN, 8'd255, 32'sd0,        1'b1);
    endtask

    task automatic test_scope_overflow();
        repeat (SCOPE_DEPTH) send_word(KIND_OPEN, BANK_COUNT, 8'd0, 32'sd0, 1'b0);
        send_word(KIND_OPEN, BANK_NONE, 8'hff, -32'sd1, 1'b1);
        send_word(KIND_ASSIGN, BANK_DIMEN, 8'd3, 32'sd42, 1'b0);
        repeat (SCOPE_DEPTH + 1) send_word(KIND_CLOSE, BANK_COUNT, 8'd0, 32'sd0, 1'b0);
        send_word(KIND_FETCH, BANK_DIMEN, 8'd3, 32'sd0, 1'b0);
    endtask

    task automatic test_log_overflow();
        logic [1:0] bank;
        logic [7:0] slot;
        send_word(KIND_OPEN, BANK_COUNT, 8'd0, 32'sd0, 1'b0);
        // few registers, so each is saved many times
        repeat (LOG_DEPTH)
            send_word(KIND_ASSIGN, 2'($urandom_range(BANK_COUNT, BANK_GLUE)),
                      8'($urandom_range(0, 15)), pick_value(), 1'b0);
        bank = 2'($urandom_range(BANK_COUNT, BANK_GLUE));
        slot = 8'($urandom_range(0, 15));
        send_word(KIND_ASSIGN, bank, slot, 32'sh0badcafe, 1'b0);
        send_word(KIND_FETCH,  bank, slot, 32'sd0, 1'b0);
        send_word(KIND_ASSIGN, bank, slot, 32'sh600d600d, 1'b1);
        send_word(KIND_ASSIGN, BANK_NONE, slot, 32'sd1, 1'b0);
        send_word(KIND_OPEN,   BANK_COUNT, 8'd0, 32'sd0, 1'b0);
        send_word(KIND_ASSIGN, BANK_GLUE, 8'd200, 32'sd1, 1'b0);
        send_word(KIND_CLOSE,  BANK_COUNT, 8'd0, 32'sd0, 1'b0);
        send_word(KIND_FETCH,  bank, slot, 32'sd0, 1'b0);
        send_word(KIND_CLOSE,  BANK_COUNT, 8'd0, 32'sd0, 1'b0);
        for (int b = 0; b < NUM_BANKS; b++)
            for (int s = 0; s < 16; s += 5)
                send_word(KIND_FETCH, b[1:0], s[7:0], 32'sd0, 1'b0);
    endtask

    task automatic test_random_words();
        int         pick;
        logic [1:0] kind;
        logic [1:0] bank;
        logic [7:0] slot;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = KIND_ASSIGN;
            else if (pick < 72) kind = KIND_FETCH;
            else if (pick < 85) kind = KIND_OPEN;
            else                kind = KIND_CLOSE;
            bank = ($urandom_range(0, 19) == 0) ? BANK_NONE
                                                : 2'($urandom_range(BANK_COUNT, BANK_GLUE));
            // a small pool of hot registers keeps fetches and restores meaningful
            case ($urandom_range(0, 3))
                0:       slot = 8'($urandom);
                1:       slot = 8'(8'd248 + $urandom_range(0, 7));
                default: slot = 8'($urandom_range(0, 7));
            endcase
            send_word(kind, bank, slot, pick_value(), ($urandom_range(0, 9) < 3));
        end
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_FETCH;
        in_if.bank      = BANK_COUNT;
        in_if.slot      = '0;
        in_if.new_value = '0;
        in_if.is_global = 1'b0;
        i_rst_n         = 1'b0;
        for (int b = 0; b < NUM_BANKS; b++)
            for (int s = 0; s < SLOTS; s++)
                bank_regs[b][s] = '0;
        undo_fill   = 0;
        scope_level = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_scope_overflow();
        test_log_overflow();
        test_random_words();

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (awaited_replies.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("%0t ns: timeout, %0d results still expected", $time, awaited_replies.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
